>>> src/hcr_pkg.sv
// ----------------------------------------------------------------------------
// hcr_pkg: shared types and constants of the HSB colour ramp generator
// Fixed-point formats, register indexes, stage enables and the reciprocal
// table that turns the division by the ramp length into a multiplication.
// ----------------------------------------------------------------------------
package hcr_pkg;

	localparam int FRAC_BITS = 16;
	localparam int MAX_STEPS = 64;
	localparam int IDX_W     = 6;
	localparam int REG_W     = FRAC_BITS + 1;
	localparam int LEN_W     = 7;
	localparam int CFG_IDX_W = 3;
	localparam int COL_W     = 8;
	localparam int TAB_W     = $clog2(MAX_STEPS);

	// Interpolation arithmetic.
	localparam int DIFF_W      = REG_W + 1;
	localparam int PROD_W      = DIFF_W + IDX_W + 1;
	localparam int MAG_W       = REG_W + IDX_W;
	localparam int RECIP_SHIFT = MAG_W + TAB_W + 1;
	localparam int REC_W       = RECIP_SHIFT + 1;
	localparam int QPROD_W     = MAG_W + REC_W;
	localparam int VAL_W       = MAG_W + 2;

	// Colour conversion arithmetic.
	localparam int H6_W   = FRAC_BITS + 3;
	localparam int B255_W = FRAC_BITS + COL_W;
	localparam int SF_W   = 2 * REG_W;
	localparam int PQT_W  = B255_W + REG_W;

	localparam logic [REG_W-1:0]        ONE_U   = REG_W'(1 << FRAC_BITS);
	localparam logic signed [VAL_W-1:0] ONE_VAL = VAL_W'(1 << FRAC_BITS);

	// Register indexes of the configuration port.
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_HUE_START    = 3'd0,
		REG_SAT_START    = 3'd1,
		REG_BRIGHT_START = 3'd2,
		REG_HUE_END      = 3'd3,
		REG_SAT_END      = 3'd4,
		REG_BRIGHT_END   = 3'd5,
		REG_RAMP_LENGTH  = 3'd6
	} hcr_reg_idx_t;

	// Stage load enables handed to the sub-blocks.
	typedef struct packed {
		logic s1;
		logic s2;
		logic s3;
	} hcr_lerp_en_t;

	typedef struct packed {
		logic s4;
		logic s5;
		logic s6;
	} hcr_conv_en_t;

	// Entry d-1 holds ceil(2^RECIP_SHIFT / d). For numerators below 2^MAG_W
	// a multiply and shift by RECIP_SHIFT then gives the exact floor quotient.
	localparam longint unsigned RN = (64'd1 << RECIP_SHIFT) - 64'd1;

	localparam logic [REC_W-1:0] RECIP_TABLE [MAX_STEPS] = '{
		REC_W'(RN / 1 + 1),  REC_W'(RN / 2 + 1),  REC_W'(RN / 3 + 1),  REC_W'(RN / 4 + 1),
		REC_W'(RN / 5 + 1),  REC_W'(RN / 6 + 1),  REC_W'(RN / 7 + 1),  REC_W'(RN / 8 + 1),
		REC_W'(RN / 9 + 1),  REC_W'(RN / 10 + 1), REC_W'(RN / 11 + 1), REC_W'(RN / 12 + 1),
		REC_W'(RN / 13 + 1), REC_W'(RN / 14 + 1), REC_W'(RN / 15 + 1), REC_W'(RN / 16 + 1),
		REC_W'(RN / 17 + 1), REC_W'(RN / 18 + 1), REC_W'(RN / 19 + 1), REC_W'(RN / 20 + 1),
		REC_W'(RN / 21 + 1), REC_W'(RN / 22 + 1), REC_W'(RN / 23 + 1), REC_W'(RN / 24 + 1),
		REC_W'(RN / 25 + 1), REC_W'(RN / 26 + 1), REC_W'(RN / 27 + 1), REC_W'(RN / 28 + 1),
		REC_W'(RN / 29 + 1), REC_W'(RN / 30 + 1), REC_W'(RN / 31 + 1), REC_W'(RN / 32 + 1),
		REC_W'(RN / 33 + 1), REC_W'(RN / 34 + 1), REC_W'(RN / 35 + 1), REC_W'(RN / 36 + 1),
		REC_W'(RN / 37 + 1), REC_W'(RN / 38 + 1), REC_W'(RN / 39 + 1), REC_W'(RN / 40 + 1),
		REC_W'(RN / 41 + 1), REC_W'(RN / 42 + 1), REC_W'(RN / 43 + 1), REC_W'(RN / 44 + 1),
		REC_W'(RN / 45 + 1), REC_W'(RN / 46 + 1), REC_W'(RN / 47 + 1), REC_W'(RN / 48 + 1),
		REC_W'(RN / 49 + 1), REC_W'(RN / 50 + 1), REC_W'(RN / 51 + 1), REC_W'(RN / 52 + 1),
		REC_W'(RN / 53 + 1), REC_W'(RN / 54 + 1), REC_W'(RN / 55 + 1), REC_W'(RN / 56 + 1),
		REC_W'(RN / 57 + 1), REC_W'(RN / 58 + 1), REC_W'(RN / 59 + 1), REC_W'(RN / 60 + 1),
		REC_W'(RN / 61 + 1), REC_W'(RN / 62 + 1), REC_W'(RN / 63 + 1), REC_W'(RN / 64 + 1)
	};

endpackage

>>> src/hsv_color_ramp_generator.sv
// The first of the six stages registers the step index at the edge that accepts
// it; stages two to six then carry it through to the colour output.
// Throughput: one transaction per cycle unless the output stalls; every one of
// the six pipeline stages holds an item; the last stage is the output register.
// Reset: arst_n clears all valid bits and loads the register defaults
// (a full hue sweep at full saturation and brightness over 64 steps).
// ----------------------------------------------------------------------------
// hsv_color_ramp_generator: HSB colour ramp to 8-bit RGB
// Interpolates hue, saturation and brightness between two configured
// endpoints for a step index and converts the point to red, green and blue.
// ----------------------------------------------------------------------------
module hsv_color_ramp_generator import hcr_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	// Configuration write port.
	input  logic                 cfg_write,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [REG_W-1:0]     cfg_data,
	// Step index channel.
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [IDX_W-1:0]     step_index,
	// Colour channel.
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [COL_W-1:0]     red,
	output logic [COL_W-1:0]     green,
	output logic [COL_W-1:0]     blue
);

	// Configuration registers. The user must change them only while the
	// pipeline is empty; the block does not check. Every stage reads them directly.
	logic [REG_W-1:0] hue_start_q;
	logic [REG_W-1:0] sat_start_q;
	logic [REG_W-1:0] bright_start_q;
	logic [REG_W-1:0] hue_end_q;
	logic [REG_W-1:0] sat_end_q;
	logic [REG_W-1:0] bright_end_q;
	logic [LEN_W-1:0] ramp_length_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hue_start_q    <= '0;
			sat_start_q    <= ONE_U;
			bright_start_q <= ONE_U;
			hue_end_q      <= ONE_U;
			sat_end_q      <= ONE_U;
			bright_end_q   <= ONE_U;
			ramp_length_q  <= LEN_W'(MAX_STEPS);
		end else if (cfg_write) begin
			case (cfg_index)
				REG_HUE_START:    hue_start_q    <= cfg_data;
				REG_SAT_START:    sat_start_q    <= cfg_data;
				REG_BRIGHT_START: bright_start_q <= cfg_data;
				REG_HUE_END:      hue_end_q      <= cfg_data;
				REG_SAT_END:      sat_end_q      <= cfg_data;
				REG_BRIGHT_END:   bright_end_q   <= cfg_data;
				REG_RAMP_LENGTH:  ramp_length_q  <= cfg_data[LEN_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// Pipeline control. Each stage loads when it is empty or when the stage
	// after it loads in the same cycle, so bubbles are squeezed out while the
	// output is stalled and nothing is dropped or repeated.
	logic valid_s1, valid_s2, valid_s3, valid_s4, valid_s5, valid_s6;
	logic en1, en2, en3, en4, en5, en6;

	assign en6 = !valid_s6 || out_ready;
	assign en5 = !valid_s5 || en6;
	assign en4 = !valid_s4 || en5;
	assign en3 = !valid_s3 || en4;
	assign en2 = !valid_s2 || en3;
	assign en1 = !valid_s1 || en2;

	assign in_ready  = en1;
	assign out_valid = valid_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
		end else begin
			if (en1) valid_s1 <= in_valid;
			if (en2) valid_s2 <= valid_s1;
			if (en3) valid_s3 <= valid_s2;
			if (en4) valid_s4 <= valid_s3;
			if (en5) valid_s5 <= valid_s4;
			if (en6) valid_s6 <= valid_s5;
		end
	end

	hcr_lerp_en_t lerp_en;
	hcr_conv_en_t conv_en;

	assign lerp_en = '{s1: en1, s2: en2, s3: en3};
	assign conv_en = '{s4: en4, s5: en5, s6: en6};

	// The ramp length is forced into 1 to MAX_STEPS and its reciprocal is
	// looked up once in the first stage for all three channels.
	logic [LEN_W-1:0] len_c;
	logic [LEN_W-1:0] len_m1;
	logic [REC_W-1:0] recip_s1;

	always_comb begin
		if (ramp_length_q == '0) begin
			len_c = LEN_W'(1);
		end else if (ramp_length_q > LEN_W'(MAX_STEPS)) begin
			len_c = LEN_W'(MAX_STEPS);
		end else begin
			len_c = ramp_length_q;
		end
	end

	assign len_m1 = len_c - LEN_W'(1);

	always_ff @(posedge clk) begin
		if (en1) begin
			recip_s1 <= RECIP_TABLE[len_m1[TAB_W-1:0]];
		end
	end

	// Stages one to three: interpolation of hue, saturation and brightness.
	logic signed [VAL_W-1:0] hue_v;
	logic signed [VAL_W-1:0] sat_v;
	logic signed [VAL_W-1:0] bright_v;

	hcr_lerp u_lerp_hue (
		.clk       (clk),
		.en        (lerp_en),
		.idx       (step_index),
		.val_start (hue_start_q),
		.val_end   (hue_end_q),
		.recip     (recip_s1),
		.value     (hue_v)
	);

	hcr_lerp u_lerp_sat (
		.clk       (clk),
		.en        (lerp_en),
		.idx       (step_index),
		.val_start (sat_start_q),
		.val_end   (sat_end_q),
		.recip     (recip_s1),
		.value     (sat_v)
	);

	hcr_lerp u_lerp_bright (
		.clk       (clk),
		.en        (lerp_en),
		.idx       (step_index),
		.val_start (bright_start_q),
		.val_end   (bright_end_q),
		.recip     (recip_s1),
		.value     (bright_v)
	);

	// Stages four to six: hue sector split and the RGB formula. The sixth
	// stage is the output register, which holds the colour during a stall.
	hcr_hsv2rgb u_hsv2rgb (
		.clk      (clk),
		.en       (conv_en),
		.hue_v    (hue_v),
		.sat_v    (sat_v),
		.bright_v (bright_v),
		.red      (red),
		.green    (green),
		.blue     (blue)
	);

endmodule

>>> src/hcr_lerp.sv
// ----------------------------------------------------------------------------
// hcr_lerp: three-stage linear interpolation of one HSB channel
// Computes start + trunc(index * (end - start) / length) with the division
// done as a multiplication by a tabulated reciprocal.
// ----------------------------------------------------------------------------
module hcr_lerp import hcr_pkg::*; (
	input  logic                    clk,
	input  hcr_lerp_en_t            en,
	input  logic [IDX_W-1:0]        idx,
	input  logic [REG_W-1:0]        val_start,
	input  logic [REG_W-1:0]        val_end,
	input  logic [REC_W-1:0]        recip,
	output logic signed [VAL_W-1:0] value
);

	logic signed [DIFF_W-1:0] diff;
	logic signed [PROD_W-1:0] prod;
	logic [PROD_W-1:0]        mag_full;
	logic [QPROD_W-1:0]       qprod;
	logic signed [VAL_W-1:0]  base;
	logic signed [VAL_W-1:0]  quot_ext;

	logic [MAG_W-1:0]        mag_s1;
	logic                    neg_s1;
	logic [MAG_W-1:0]        quot_s2;
	logic                    neg_s2;
	logic signed [VAL_W-1:0] value_s3;

	assign diff     = signed'({1'b0, val_end}) - signed'({1'b0, val_start});
	assign prod     = PROD_W'(diff) * PROD_W'(signed'({1'b0, idx}));
	assign mag_full = prod[PROD_W-1] ? PROD_W'(-prod) : prod;

	// Stage 1: signed product and its magnitude.
	always_ff @(posedge clk) begin
		if (en.s1) begin
			mag_s1 <= mag_full[MAG_W-1:0];
			neg_s1 <= prod[PROD_W-1];
		end
	end

	// Stage 2: magnitude divided by the length, truncated.
	assign qprod = QPROD_W'(mag_s1) * QPROD_W'(recip);

	always_ff @(posedge clk) begin
		if (en.s2) begin
			quot_s2 <= qprod[RECIP_SHIFT+MAG_W-1:RECIP_SHIFT];
			neg_s2  <= neg_s1;
		end
	end

	// Stage 3: apply the sign, which truncates toward zero, and add the start.
	assign base     = signed'(VAL_W'(val_start));
	assign quot_ext = signed'(VAL_W'(quot_s2));

	always_ff @(posedge clk) begin
		if (en.s3) begin
			value_s3 <= neg_s2 ? base - quot_ext : base + quot_ext;
		end
	end

	assign value = value_s3;

endmodule

>>> src/hcr_hsv2rgb.sv
// ----------------------------------------------------------------------------
// hcr_hsv2rgb: three-stage HSB to 8-bit RGB conversion
// Wraps hue, clamps saturation and brightness, and forms bb, p, q and t.
// ----------------------------------------------------------------------------
module hcr_hsv2rgb import hcr_pkg::*; (
	input  logic                    clk,
	input  hcr_conv_en_t            en,
	input  logic signed [VAL_W-1:0] hue_v,
	input  logic signed [VAL_W-1:0] sat_v,
	input  logic signed [VAL_W-1:0] bright_v,
	output logic [COL_W-1:0]        red,
	output logic [COL_W-1:0]        green,
	output logic [COL_W-1:0]        blue
);

	localparam logic [2:0] SEC_RED     = 3'd0;
	localparam logic [2:0] SEC_YELLOW  = 3'd1;
	localparam logic [2:0] SEC_GREEN   = 3'd2;
	localparam logic [2:0] SEC_CYAN    = 3'd3;
	localparam logic [2:0] SEC_BLUE    = 3'd4;
	localparam logic [2:0] SEC_MAGENTA = 3'd5;

	logic [FRAC_BITS-1:0] hue;
	logic [H6_W-1:0]      h6;
	logic [REG_W-1:0]     sat_c;
	logic [REG_W-1:0]     bright_c;
	logic [B255_W:0]      b255_full;
	logic [SF_W-1:0]      sf_prod;
	logic [SF_W-1:0]      sf1_prod;
	logic [PQT_W-1:0]     p_prod;
	logic [PQT_W-1:0]     q_prod;
	logic [PQT_W-1:0]     t_prod;
	logic [COL_W-1:0]     q_val;
	logic [COL_W-1:0]     t_val;

	logic [2:0]           sector_s4;
	logic [FRAC_BITS-1:0] f_s4;
	logic [REG_W-1:0]     sat_s4;
	logic [B255_W-1:0]    b255_s4;

	logic [2:0]           sector_s5;
	logic [B255_W-1:0]    b255_s5;
	logic [REG_W-1:0]     sf_s5;
	logic [REG_W-1:0]     sf1_s5;
	logic [COL_W-1:0]     p_s5;
	logic [COL_W-1:0]     bb_s5;

	logic [COL_W-1:0]     red_s6;
	logic [COL_W-1:0]     green_s6;
	logic [COL_W-1:0]     blue_s6;

	// Stage 4: hue fraction times six, clamping, brightness times 255.
	assign hue = hue_v[FRAC_BITS-1:0];
	assign h6  = (H6_W'(hue) << 2) + (H6_W'(hue) << 1);

	always_comb begin
		if (sat_v < 0) begin
			sat_c = '0;
		end else if (sat_v > ONE_VAL) begin
			sat_c = ONE_U;
		end else begin
			sat_c = sat_v[REG_W-1:0];
		end
		if (bright_v < 0) begin
			bright_c = '0;
		end else if (bright_v > ONE_VAL) begin
			bright_c = ONE_U;
		end else begin
			bright_c = bright_v[REG_W-1:0];
		end
	end

	assign b255_full = ((B255_W + 1)'(bright_c) << COL_W) - (B255_W + 1)'(bright_c);

	always_ff @(posedge clk) begin
		if (en.s4) begin
			sector_s4 <= h6[H6_W-1:FRAC_BITS];
			f_s4      <= h6[FRAC_BITS-1:0];
			sat_s4    <= sat_c;
			b255_s4   <= b255_full[B255_W-1:0];
		end
	end

	// Stage 5: scaled fractions and p.
	assign sf_prod  = SF_W'(sat_s4) * SF_W'(f_s4);
	assign sf1_prod = SF_W'(sat_s4) * SF_W'(ONE_U - REG_W'(f_s4));
	assign p_prod   = PQT_W'(b255_s4) * PQT_W'(ONE_U - sat_s4);

	always_ff @(posedge clk) begin
		if (en.s5) begin
			sector_s5 <= sector_s4;
			b255_s5   <= b255_s4;
			sf_s5     <= sf_prod[FRAC_BITS+REG_W-1:FRAC_BITS];
			sf1_s5    <= sf1_prod[FRAC_BITS+REG_W-1:FRAC_BITS];
			p_s5      <= p_prod[2*FRAC_BITS+COL_W-1:2*FRAC_BITS];
			bb_s5     <= b255_s4[B255_W-1:FRAC_BITS];
		end
	end

	// Stage 6: q and t, then the sector picks the channel order.
	assign q_prod = PQT_W'(b255_s5) * PQT_W'(ONE_U - sf_s5);
	assign t_prod = PQT_W'(b255_s5) * PQT_W'(ONE_U - sf1_s5);
	assign q_val  = q_prod[2*FRAC_BITS+COL_W-1:2*FRAC_BITS];
	assign t_val  = t_prod[2*FRAC_BITS+COL_W-1:2*FRAC_BITS];

	always_ff @(posedge clk) begin
		if (en.s6) begin
			case (sector_s5)
				SEC_RED: begin
					red_s6 <= bb_s5; green_s6 <= t_val; blue_s6 <= p_s5;
				end
				SEC_YELLOW: begin
					red_s6 <= q_val; green_s6 <= bb_s5; blue_s6 <= p_s5;
				end
				SEC_GREEN: begin
					red_s6 <= p_s5; green_s6 <= bb_s5; blue_s6 <= t_val;
				end
				SEC_CYAN: begin
					red_s6 <= p_s5; green_s6 <= q_val; blue_s6 <= bb_s5;
				end
				SEC_BLUE: begin
					red_s6 <= t_val; green_s6 <= p_s5; blue_s6 <= bb_s5;
				end
				SEC_MAGENTA: begin
					red_s6 <= bb_s5; green_s6 <= p_s5; blue_s6 <= q_val;
				end
				default: begin
					red_s6 <= bb_s5; green_s6 <= p_s5; blue_s6 <= q_val;
				end
			endcase
		end
	end

	assign red   = red_s6;
	assign green = green_s6;
	assign blue  = blue_s6;

endmodule
